// ===== design/nds_pkg.sv =====
// ----------------------------------------------------------------------------
// nds_pkg: shared types and constants of the delimiter span scanner
// Character codes, byte classes, status and sub-mode codes, config indexes.
// ----------------------------------------------------------------------------
package nds_pkg;

  // default sizes, handed down from the top level
  localparam int MAX_NEST_DEF     = 32;
  localparam int DEPTH_WIDTH_DEF  = 8;
  localparam int LINE_WIDTH_DEF   = 20;
  localparam int OFFSET_WIDTH_DEF = 24;
  localparam int QUEUE_DEPTH_DEF  = 2;

  // config write port
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_KIND    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = CFG_IDX_W'(1);

  // opener kinds
  localparam logic [1:0] KIND_PAREN   = 2'd0;
  localparam logic [1:0] KIND_BRACKET = 2'd1;
  localparam logic [1:0] KIND_BRACE   = 2'd2;
  localparam logic [1:0] KIND_LITERAL = 2'd3;

  // characters of interest
  localparam logic [7:0] CHAR_LPAREN  = 8'h28;
  localparam logic [7:0] CHAR_RPAREN  = 8'h29;
  localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
  localparam logic [7:0] CHAR_RBRACK  = 8'h5D;
  localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE  = 8'h7D;
  localparam logic [7:0] CHAR_QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  typedef enum logic [3:0] {
    CC_OTHER,
    CC_LPAREN,
    CC_RPAREN,
    CC_LBRACK,
    CC_RBRACK,
    CC_LBRACE,
    CC_RBRACE,
    CC_QUOTE,
    CC_BSLASH,
    CC_NEWLINE
  } char_class_e;

  typedef enum logic [2:0] {
    ST_RUNNING   = 3'd0,
    ST_MATCHED   = 3'd1,
    ST_UNMATCHED = 3'd2,
    ST_TOO_DEEP  = 3'd3,
    ST_DEPTH_OVF = 3'd4,
    ST_IGNORED   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    SUB_NONE  = 3'b001,
    SUB_LIT   = 3'b010,
    SUB_QUOTE = 3'b100
  } sub_mode_e;

  // classified word passed from front to back
  typedef struct packed {
    char_class_e cls;
    logic        first;
    logic        last;
  } word_t;

endpackage

// ===== design/nds_intf.sv =====
// ----------------------------------------------------------------------------
// nds_intf: channel interfaces of the delimiter span scanner
// Input byte channel, result channel and config write channel.
// ----------------------------------------------------------------------------
interface nds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface nds_out_if #(
  parameter int LINE_W = nds_pkg::LINE_WIDTH_DEF,
  parameter int OFF_W  = nds_pkg::OFFSET_WIDTH_DEF
);
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [LINE_W-1:0] error_line;
  logic [OFF_W-1:0]  end_offset;

  modport source (output valid, status, error_line, end_offset, input ready);
  modport sink   (input valid, status, error_line, end_offset, output ready);
endinterface

interface nds_cfg_if #(
  parameter int IDX_W  = nds_pkg::CFG_IDX_W,
  parameter int DATA_W = nds_pkg::OFFSET_WIDTH_DEF
);
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/nds_ram.sv =====
// ----------------------------------------------------------------------------
// nds_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];  // read-old on collision
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/nds_front.sv =====
// ----------------------------------------------------------------------------
// nds_front: input stage of the delimiter span scanner
// Accepts input bytes and registers them as classified words.
// ----------------------------------------------------------------------------
module nds_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  nds_in_if.sink        in_i,
  output nds_pkg::word_t word_o,
  output logic          word_valid_o,
  input  logic          word_ready_i
);
  import nds_pkg::*;

  function automatic char_class_e classify(logic [7:0] c);
    char_class_e cls;
    unique case (c)
      CHAR_LPAREN:  cls = CC_LPAREN;
      CHAR_RPAREN:  cls = CC_RPAREN;
      CHAR_LBRACK:  cls = CC_LBRACK;
      CHAR_RBRACK:  cls = CC_RBRACK;
      CHAR_LBRACE:  cls = CC_LBRACE;
      CHAR_RBRACE:  cls = CC_RBRACE;
      CHAR_QUOTE:   cls = CC_QUOTE;
      CHAR_BSLASH:  cls = CC_BSLASH;
      CHAR_NEWLINE: cls = CC_NEWLINE;
      default:      cls = CC_OTHER;
    endcase
    return cls;
  endfunction

  logic  vld_q, vld_d;
  word_t word_q;
  logic  accept;

  assign in_i.ready = !vld_q || word_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (word_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q.cls   <= classify(in_i.data_byte);
      word_q.first <= in_i.first_byte;
      word_q.last  <= in_i.last_byte;
    end
  end

  assign word_o       = word_q;
  assign word_valid_o = vld_q;

endmodule

// ===== design/nds_fifo.sv =====
// ----------------------------------------------------------------------------
// nds_fifo: short word queue between front and back
// Register-based FIFO; decouples stalls of the two sides.
// ----------------------------------------------------------------------------
module nds_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = nds_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != FULL_CNT);
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = entries[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + PW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries[wptr_q] <= in_data_i;
    end
  end

endmodule

// ===== design/nds_back.sv =====
// ----------------------------------------------------------------------------
// nds_back: execution stage of the delimiter span scanner
// Updates the frame stack and sub-modes per word and registers the result.
// ----------------------------------------------------------------------------
module nds_back #(
  parameter int MAX_NEST     = nds_pkg::MAX_NEST_DEF,
  parameter int DEPTH_WIDTH  = nds_pkg::DEPTH_WIDTH_DEF,
  parameter int LINE_WIDTH   = nds_pkg::LINE_WIDTH_DEF,
  parameter int OFFSET_WIDTH = nds_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  nds_pkg::word_t          word_i,
  input  logic                    word_valid_i,
  output logic                    word_ready_o,
  input  logic [1:0]              open_kind_i,
  input  logic [OFFSET_WIDTH-1:0] start_offset_i,
  nds_out_if.source               out_o
);
  import nds_pkg::*;

  localparam int CW = $clog2(MAX_NEST + 2);
  localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
  localparam logic [DEPTH_WIDTH-1:0]  DEPTH_MAX = '1;
  localparam logic [LINE_WIDTH-1:0]   LINE_MAX  = '1;
  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX   = '1;
  localparam logic [CW-1:0]           NEST_LIM  = CW'(MAX_NEST);

  typedef struct packed {
    logic [1:0]             kind;
    logic [DEPTH_WIDTH-1:0] depth;
    logic [LINE_WIDTH-1:0]  line;
  } frame_t;

  function automatic char_class_e open_class(logic [1:0] kind);
    char_class_e cls;
    case (kind)
      KIND_BRACKET: cls = CC_LBRACK;
      KIND_BRACE:   cls = CC_LBRACE;
      default:      cls = CC_LPAREN;
    endcase
    return cls;
  endfunction

  function automatic char_class_e close_class(logic [1:0] kind);
    char_class_e cls;
    case (kind)
      KIND_BRACKET: cls = CC_RBRACK;
      KIND_BRACE:   cls = CC_RBRACE;
      default:      cls = CC_RPAREN;
    endcase
    return cls;
  endfunction

  // scan state
  logic [CW-1:0]           cnt_q, cnt_d;
  sub_mode_e               sub_q, sub_d;
  logic [DEPTH_WIDTH-1:0]  lit_q, lit_d;
  logic [LINE_WIDTH-1:0]   sline_q, sline_d;
  logic                    esc_q, esc_d;
  logic [LINE_WIDTH-1:0]   line_q, line_d;
  logic [OFFSET_WIDTH-1:0] pos_q, pos_d;
  logic                    done_q, done_d;
  frame_t                  top_q, top_d;
  frame_t                  byp_q;
  logic                    byp_vld_q, byp_vld_d;

  // result register
  logic                    ov_q, ov_d;
  status_e                 ost_q;
  logic [LINE_WIDTH-1:0]   oline_q;
  logic [OFFSET_WIDTH-1:0] oend_q;

  // working values
  logic [CW-1:0]           cnt_c, cnt_n, rtmp, wtmp;
  sub_mode_e               sub_c, sub_n;
  logic [DEPTH_WIDTH-1:0]  lit_c, lit_n;
  logic [LINE_WIDTH-1:0]   sline_c, sline_n, line_c, line_n, eline;
  logic                    esc_c, esc_n, done_c, done_n;
  logic [OFFSET_WIDTH-1:0] pos_c, pos_n, end_v;
  logic [OFFSET_WIDTH:0]   end_sum;
  frame_t                  top_c, top_n, below;
  status_e                 status;
  logic                    fire, ignored, push, do_push;
  logic [1:0]              push_kind;

  // frames below the top
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [$bits(frame_t)-1:0] rdata;

  assign word_ready_o = !ov_q || out_o.ready;
  assign fire         = word_valid_i && word_ready_o;

  always_comb begin
    // state as seen by this word, after a scan start
    cnt_c   = cnt_q;
    sub_c   = sub_q;
    lit_c   = lit_q;
    sline_c = sline_q;
    esc_c   = esc_q;
    line_c  = line_q;
    pos_c   = pos_q;
    done_c  = done_q;
    top_c   = top_q;
    if (word_i.first) begin
      esc_c  = 1'b0;
      line_c = LINE_WIDTH'(1);
      pos_c  = '0;
      done_c = 1'b0;
      top_c  = '{kind: open_kind_i, depth: DEPTH_WIDTH'(1), line: LINE_WIDTH'(1)};
      if (open_kind_i == KIND_LITERAL) begin
        cnt_c   = '0;
        sub_c   = SUB_LIT;
        lit_c   = DEPTH_WIDTH'(1);
        sline_c = LINE_WIDTH'(1);
      end else begin
        cnt_c   = CW'(1);
        sub_c   = SUB_NONE;
        lit_c   = '0;
        sline_c = '0;
      end
    end

    below   = byp_vld_q ? byp_q : frame_t'(rdata);
    ignored = done_c || (cnt_c == '0 && sub_c == SUB_NONE);

    cnt_n   = cnt_c;
    sub_n   = sub_c;
    lit_n   = lit_c;
    sline_n = sline_c;
    esc_n   = esc_c;
    top_n   = top_c;
    status  = ST_RUNNING;
    eline   = '0;
    push      = 1'b0;
    push_kind = KIND_PAREN;
    do_push   = 1'b0;

    pos_n   = (pos_c != OFF_MAX) ? pos_c + OFFSET_WIDTH'(1) : pos_c;
    end_sum = {1'b0, start_offset_i} + {1'b0, pos_n};
    end_v   = end_sum[OFFSET_WIDTH] ? OFF_MAX : end_sum[OFFSET_WIDTH-1:0];
    line_n  = (word_i.cls == CC_NEWLINE && line_c != LINE_MAX) ?
              line_c + LINE_WIDTH'(1) : line_c;

    if (esc_c) begin
      esc_n = 1'b0;
    end else if (sub_c == SUB_QUOTE) begin
      if (word_i.cls == CC_QUOTE) begin
        sub_n = SUB_NONE;
      end else if (word_i.cls == CC_BSLASH) begin
        esc_n = 1'b1;
      end
    end else if (sub_c == SUB_LIT) begin
      if (word_i.cls == CC_BSLASH) begin
        esc_n = 1'b1;
      end else if (word_i.cls == CC_LBRACE) begin
        if (lit_c == DEPTH_MAX) begin
          status = ST_DEPTH_OVF;
          eline  = sline_c;
        end else begin
          lit_n = lit_c + DEPTH_WIDTH'(1);
        end
      end else if (word_i.cls == CC_RBRACE) begin
        lit_n = lit_c - DEPTH_WIDTH'(1);
        if (lit_c == DEPTH_WIDTH'(1)) begin
          sub_n = SUB_NONE;
          if (cnt_c == '0) begin
            status = ST_MATCHED;
          end
        end
      end
    end else begin
      // inside the top frame
      if (word_i.cls == CC_BSLASH) begin
        esc_n = 1'b1;
      end else if (word_i.cls == open_class(top_c.kind)) begin
        if (top_c.depth == DEPTH_MAX) begin
          status = ST_DEPTH_OVF;
          eline  = top_c.line;
        end else begin
          top_n.depth = top_c.depth + DEPTH_WIDTH'(1);
        end
      end else if (word_i.cls == close_class(top_c.kind)) begin
        top_n.depth = top_c.depth - DEPTH_WIDTH'(1);
        if (top_c.depth == DEPTH_WIDTH'(1)) begin
          cnt_n = cnt_c - CW'(1);
          top_n = below;
          if (cnt_c == CW'(1)) begin
            status = ST_MATCHED;
          end
        end
      end else if (word_i.cls == CC_LBRACE) begin
        sub_n   = SUB_LIT;
        lit_n   = DEPTH_WIDTH'(1);
        sline_n = line_n;
      end else if (word_i.cls == CC_LPAREN) begin
        push      = 1'b1;
        push_kind = KIND_PAREN;
      end else if (word_i.cls == CC_LBRACK) begin
        push      = 1'b1;
        push_kind = KIND_BRACKET;
      end else if (word_i.cls == CC_QUOTE) begin
        sub_n   = SUB_QUOTE;
        sline_n = line_n;
      end
    end

    if (push) begin
      if (cnt_c > NEST_LIM) begin
        status = ST_TOO_DEEP;
        eline  = line_n;
      end else begin
        do_push = 1'b1;
        cnt_n   = cnt_c + CW'(1);
        top_n   = '{kind: push_kind, depth: DEPTH_WIDTH'(1), line: line_n};
      end
    end

    // end of input without a match
    if (status == ST_RUNNING && word_i.last) begin
      status = ST_UNMATCHED;
      if (sub_n != SUB_NONE) begin
        eline = sline_n;
      end else if (cnt_n != '0) begin
        eline = top_n.line;
      end else begin
        eline = line_n;
      end
    end
    done_n = (status != ST_RUNNING);

    // commit
    cnt_d   = cnt_q;
    sub_d   = sub_q;
    lit_d   = lit_q;
    sline_d = sline_q;
    esc_d   = esc_q;
    line_d  = line_q;
    pos_d   = pos_q;
    done_d  = done_q;
    top_d   = top_q;
    we      = 1'b0;
    if (fire && !ignored) begin
      cnt_d   = cnt_n;
      sub_d   = sub_n;
      lit_d   = lit_n;
      sline_d = sline_n;
      esc_d   = esc_n;
      line_d  = line_n;
      pos_d   = pos_n;
      done_d  = done_n;
      top_d   = top_n;
      we      = do_push;
    end

    // old top goes to the slot under the new one; the read port always
    // tracks the frame directly under the top
    wtmp      = cnt_c - CW'(1);
    waddr     = wtmp[AW-1:0];
    rtmp      = cnt_d - CW'(2);
    raddr     = rtmp[AW-1:0];
    byp_vld_d = we && (waddr == raddr);

    ov_d = ov_q;
    if (fire) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  nds_ram #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (MAX_NEST),
    .AW    (AW)
  ) u_frames (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (top_c),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      sub_q     <= SUB_NONE;
      lit_q     <= '0;
      sline_q   <= '0;
      esc_q     <= 1'b0;
      line_q    <= LINE_WIDTH'(1);
      pos_q     <= '0;
      done_q    <= 1'b0;
      byp_vld_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      sub_q     <= sub_d;
      lit_q     <= lit_d;
      sline_q   <= sline_d;
      esc_q     <= esc_d;
      line_q    <= line_d;
      pos_q     <= pos_d;
      done_q    <= done_d;
      byp_vld_q <= byp_vld_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (we) begin
      byp_q <= top_c;
    end
    if (fire) begin
      if (ignored) begin
        ost_q   <= ST_IGNORED;
        oline_q <= '0;
        oend_q  <= '0;
      end else begin
        ost_q   <= status;
        oline_q <= eline;
        oend_q  <= end_v;
      end
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.status     = ost_q;
  assign out_o.error_line = oline_q;
  assign out_o.end_offset = oend_q;

endmodule

// ===== design/nested_delimiter_span_scanner_core.sv =====
// ----------------------------------------------------------------------------
// nested_delimiter_span_scanner_core: balanced delimiter span scanner
// Finds the closer matching an already consumed opener, one byte per word.
// ----------------------------------------------------------------------------
// Throughput: one byte word per cycle while the result channel is not
//   stalled, with no bubbles on stack push or pop (the frame under the top
//   is always prefetched from the RAM). A byte passes the front register,
//   the queue and then the result register before its result word is valid.
// Reset: asynchronous, active low; clears the handshake, queue and scan
//   state. The frame RAM is not cleared; frames are written before use.
// ----------------------------------------------------------------------------
module nested_delimiter_span_scanner_core #(
  parameter int MAX_NEST     = nds_pkg::MAX_NEST_DEF,
  parameter int DEPTH_WIDTH  = nds_pkg::DEPTH_WIDTH_DEF,
  parameter int LINE_WIDTH   = nds_pkg::LINE_WIDTH_DEF,
  parameter int OFFSET_WIDTH = nds_pkg::OFFSET_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nds_in_if.sink    in_i,
  nds_out_if.source out_o,
  nds_cfg_if.sink   cfg_i
);
  import nds_pkg::*;

  localparam int WORD_W = $bits(word_t);

  // config registers; the user must write them only while idle, the block does not enforce it
  logic [1:0]              open_kind_q;
  logic [OFFSET_WIDTH-1:0] start_offset_q;

  // front -> queue
  word_t             f_word;
  logic              f_valid, f_ready;
  // queue -> back
  logic [WORD_W-1:0] q_data;
  logic              q_valid, q_ready;
  word_t             b_word;

  // the config port never stalls
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_kind_q    <= KIND_PAREN;
      start_offset_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_OPEN_KIND:    open_kind_q    <= cfg_i.data[1:0];
        CFG_START_OFFSET: start_offset_q <= cfg_i.data[OFFSET_WIDTH-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // front: accept and classify bytes
  nds_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .word_o       (f_word),
    .word_valid_o (f_valid),
    .word_ready_i (f_ready)
  );

  // short queue so front and back stall independently
  nds_fifo #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_word),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  assign b_word = word_t'(q_data);

  // back: frame stack, sub-modes, counters, result register
  nds_back #(
    .MAX_NEST     (MAX_NEST),
    .DEPTH_WIDTH  (DEPTH_WIDTH),
    .LINE_WIDTH   (LINE_WIDTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .word_i         (b_word),
    .word_valid_i   (q_valid),
    .word_ready_o   (q_ready),
    .open_kind_i    (open_kind_q),
    .start_offset_i (start_offset_q),
    .out_o          (out_o)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for nested_delimiter_span_scanner_core
// Streams script bytes through the scanner with random gaps on both sides but in
// one full-speed phase, tracks the expected span status per byte word and checks
// every result.
module tb;
  import nds_pkg::*;

  localparam int LW      = LINE_WIDTH_DEF;
  localparam int OW      = OFFSET_WIDTH_DEF;
  localparam int DW      = DEPTH_WIDTH_DEF;
  localparam int NFRAMES = MAX_NEST_DEF + 1;

  // one source byte word
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } src_word_t;

  // one scanner result word
  typedef struct packed {
    logic [2:0]    status;
    logic [LW-1:0] error_line;
    logic [OW-1:0] end_offset;
  } span_res_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #10 clk = ~clk;

  nds_in_if  in_if ();
  nds_out_if out_if ();
  nds_cfg_if cfg_if ();

  nested_delimiter_span_scanner_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  src_word_t src_bytes[$];         // words waiting to be driven
  span_res_t span_results_due[$];  // predicted results, oldest first
  int        n_words    = 0;
  int        n_fail     = 0;
  bit        full_speed = 1'b0;    // no random gaps on either side

  // --------------------------------------------------------------------------
  // scan state mirror
  // --------------------------------------------------------------------------
  logic [1:0]    frm_kind  [NFRAMES];
  logic [DW-1:0] frm_depth [NFRAMES];
  logic [LW-1:0] frm_line  [NFRAMES];
  int            frm_cnt   = 0;
  sub_mode_e     sub       = SUB_NONE;
  logic [DW-1:0] brace_lvl = '0;
  logic [LW-1:0] sub_line  = '0;
  bit            esc_armed = 1'b0;
  logic [LW-1:0] cur_line  = LW'(1);
  logic [OW-1:0] byte_cnt  = '0;
  bit            scan_over = 1'b0;
  logic [1:0]    cfg_kind  = KIND_PAREN;
  logic [OW-1:0] cfg_base  = '0;

  function automatic logic [7:0] opener_of(input logic [1:0] k);
    case (k)
      KIND_PAREN:   return CHAR_LPAREN;
      KIND_BRACKET: return CHAR_LBRACK;
      default:      return CHAR_LBRACE;
    endcase
  endfunction

  function automatic logic [7:0] closer_of(input logic [1:0] k);
    case (k)
      KIND_PAREN:   return CHAR_RPAREN;
      KIND_BRACKET: return CHAR_RBRACK;
      default:      return CHAR_RBRACE;
    endcase
  endfunction

  // advance the scan by one byte and return the result it should produce
  task automatic advance_span(input src_word_t w, output span_res_t r);
    logic [7:0]  c;
    status_e     st;
    logic [LW-1:0] el;
    logic [OW:0] sum;
    int          t;
    c  = w.data;
    st = ST_RUNNING;
    el = '0;
    if (w.first) begin
      // new scan: clear everything, then open the outer construct on line 1
      frm_cnt   = 0;
      sub       = SUB_NONE;
      brace_lvl = '0;
      sub_line  = '0;
      esc_armed = 1'b0;
      cur_line  = LW'(1);
      byte_cnt  = '0;
      scan_over = 1'b0;
      if (cfg_kind == KIND_LITERAL) begin
        sub       = SUB_LIT;
        brace_lvl = DW'(1);
        sub_line  = LW'(1);
      end else begin
        frm_kind[0]  = cfg_kind;
        frm_depth[0] = DW'(1);
        frm_line[0]  = LW'(1);
        frm_cnt      = 1;
      end
    end
    if (scan_over || (frm_cnt == 0 && sub == SUB_NONE)) begin
      r.status     = ST_IGNORED;
      r.error_line = '0;
      r.end_offset = '0;
      return;
    end
    if (byte_cnt != '1) byte_cnt++;
    sum = {1'b0, cfg_base} + {1'b0, byte_cnt};
    if (sum[OW]) sum[OW-1:0] = '1;
    // newlines count even when escaped or quoted
    if (c == CHAR_NEWLINE && cur_line != '1) cur_line++;

    if (esc_armed) begin
      esc_armed = 1'b0;
    end else if (sub == SUB_QUOTE) begin
      if (c == CHAR_QUOTE) sub = SUB_NONE;
      else if (c == CHAR_BSLASH) esc_armed = 1'b1;
    end else if (sub == SUB_LIT) begin
      if (c == CHAR_BSLASH) begin
        esc_armed = 1'b1;
      end else if (c == CHAR_LBRACE) begin
        if (brace_lvl == '1) begin
          st = ST_DEPTH_OVF;
          el = sub_line;
        end else begin
          brace_lvl++;
        end
      end else if (c == CHAR_RBRACE) begin
        brace_lvl--;
        if (brace_lvl == '0) begin
          sub = SUB_NONE;
          if (frm_cnt == 0) st = ST_MATCHED;
        end
      end
    end else begin
      t = frm_cnt - 1;
      if (c == CHAR_BSLASH) begin
        esc_armed = 1'b1;
      end else if (c == opener_of(frm_kind[t])) begin
        if (frm_depth[t] == '1) begin
          st = ST_DEPTH_OVF;
          el = frm_line[t];
        end else begin
          frm_depth[t]++;
        end
      end else if (c == closer_of(frm_kind[t])) begin
        frm_depth[t]--;
        if (frm_depth[t] == '0) begin
          frm_cnt--;
          if (frm_cnt == 0) st = ST_MATCHED;
        end
      end else if (c == CHAR_LBRACE) begin
        // brace inside paren/bracket: literal sub-mode
        sub       = SUB_LIT;
        brace_lvl = DW'(1);
        sub_line  = cur_line;
      end else if (c == CHAR_LPAREN || c == CHAR_LBRACK) begin
        if (frm_cnt > MAX_NEST_DEF) begin
          st = ST_TOO_DEEP;
          el = cur_line;
        end else begin
          frm_kind[frm_cnt]  = (c == CHAR_LPAREN) ? KIND_PAREN : KIND_BRACKET;
          frm_depth[frm_cnt] = DW'(1);
          frm_line[frm_cnt]  = cur_line;
          frm_cnt++;
        end
      end else if (c == CHAR_QUOTE) begin
        sub      = SUB_QUOTE;
        sub_line = cur_line;
      end
    end

    // end of input without a match: report innermost open construct
    if (st == ST_RUNNING && w.last) begin
      st = ST_UNMATCHED;
      if (sub != SUB_NONE) el = sub_line;
      else if (frm_cnt > 0) el = frm_line[frm_cnt-1];
      else el = cur_line;
    end
    if (st != ST_RUNNING) scan_over = 1'b1;
    r.status     = st;
    r.error_line = el;
    r.end_offset = sum[OW-1:0];
  endtask

  // --------------------------------------------------------------------------
  // byte driver: presents queued words, random gaps, predicts on accept
  // --------------------------------------------------------------------------
  src_word_t drv_word;
  src_word_t drv_next;
  span_res_t drv_res;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        drv_word.data  = in_if.data_byte;
        drv_word.first = in_if.first_byte;
        drv_word.last  = in_if.last_byte;
        advance_span(drv_word, drv_res);
        span_results_due.push_back(drv_res);
      end
      if (!in_if.valid || in_if.ready) begin
        if (src_bytes.size() != 0 && (full_speed || $urandom_range(99) >= 28)) begin
          drv_next = src_bytes.pop_front();
          in_if.valid      <= 1'b1;
          in_if.data_byte  <= drv_next.data;
          in_if.first_byte <= drv_next.first;
          in_if.last_byte  <= drv_next.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: random backpressure, field-by-field compare
  // --------------------------------------------------------------------------
  span_res_t mon_want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (span_results_due.size() == 0) begin
          $error("unexpected result word: status %0d", out_if.status);
          n_fail++;
        end else begin
          mon_want = span_results_due.pop_front();
          if (out_if.status !== mon_want.status) begin
            $error("status: expected %0d, got %0d", mon_want.status, out_if.status);
            n_fail++;
          end
          if (out_if.error_line !== mon_want.error_line) begin
            $error("error_line: expected %0d, got %0d",
                   mon_want.error_line, out_if.error_line);
            n_fail++;
          end
          if (out_if.end_offset !== mon_want.end_offset) begin
            $error("end_offset: expected %0d, got %0d",
                   mon_want.end_offset, out_if.end_offset);
            n_fail++;
          end
        end
      end
      out_if.ready <= full_speed || ($urandom_range(99) >= 28);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void put(input logic [7:0] b, input bit f, input bit l);
    src_word_t w;
    w.data  = b;
    w.first = f;
    w.last  = l;
    src_bytes.push_back(w);
    n_words++;
  endfunction

  // printable byte that is none of the delimiters, quote or backslash
  function automatic logic [7:0] filler();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(32, 126));
    end while (b inside {CHAR_LPAREN, CHAR_RPAREN, CHAR_LBRACK, CHAR_RBRACK,
                         CHAR_LBRACE, CHAR_RBRACE, CHAR_QUOTE, CHAR_BSLASH});
    return b;
  endfunction

  // one scan; tidy builds balanced nesting, otherwise random noise mixed in
  task automatic queue_scan(input bit tidy);
    logic [7:0] body[$];
    logic [7:0] shut[$];
    int         n_tok;
    int         sel;
    int         last_at;
    int         n_keep;
    n_tok = $urandom_range(0, 24);
    shut.push_back(closer_of(cfg_kind));
    for (int i = 0; i < n_tok; i++) begin
      case ($urandom_range(9))
        0, 1, 2: body.push_back(filler());
        3: body.push_back(CHAR_NEWLINE);
        4: begin
          sel = $urandom_range(2);
          body.push_back(sel == 0 ? CHAR_LPAREN : sel == 1 ? CHAR_LBRACK : CHAR_LBRACE);
          shut.push_back(sel == 0 ? CHAR_RPAREN : sel == 1 ? CHAR_RBRACK : CHAR_RBRACE);
        end
        5: if (shut.size() > 1) body.push_back(shut.pop_back());
        6: begin
          body.push_back(CHAR_QUOTE);
          repeat ($urandom_range(4))
            body.push_back($urandom_range(3) == 0 ? CHAR_NEWLINE : filler());
          body.push_back(CHAR_QUOTE);
        end
        7: begin
          body.push_back(CHAR_BSLASH);
          body.push_back(8'($urandom));
        end
        default: body.push_back(tidy ? filler() : 8'($urandom));
      endcase
    end
    if (tidy || $urandom_range(1)) begin
      while (shut.size() != 0) body.push_back(shut.pop_back());
    end
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
    end
    if (body.size() == 0) body.push_back(filler());
    // where the source ends: on the final byte, somewhere early, or not at all
    sel = $urandom_range(9);
    n_keep = body.size();
    if (sel < 6) begin
      last_at = n_keep - 1;
    end else if (sel < 8) begin
      last_at = $urandom_range(n_keep - 1);
      n_keep  = last_at + 1;
    end else begin
      last_at = -1;
    end
    for (int i = 0; i < n_keep; i++) put(body[i], i == 0, i == last_at);
  endtask

  // alternating paren/bracket frames, n deep, up to or past the nesting limit
  task automatic queue_deep(input int n);
    logic [7:0] shut[$];
    bit         paren_next;
    paren_next = (cfg_kind != KIND_PAREN);
    for (int i = 0; i < n; i++) begin
      put(paren_next ? CHAR_LPAREN : CHAR_LBRACK, i == 0, 1'b0);
      shut.push_front(paren_next ? CHAR_RPAREN : CHAR_RBRACK);
      paren_next = !paren_next;
    end
    shut.push_back(closer_of(cfg_kind));
    foreach (shut[i]) put(shut[i], 1'b0, i == shut.size() - 1);
  endtask

  // same-kind openers up to and past the depth counter limit
  task automatic queue_flood(input int n);
    int n_shut;
    for (int i = 0; i < n; i++) put(opener_of(cfg_kind), i == 0, 1'b0);
    // once the counter overflows the scan is over; one closer is enough
    n_shut = (n < (1 << DW) - 1) ? n + 1 : 1;
    for (int i = 0; i < n_shut; i++) put(closer_of(cfg_kind), 1'b0, i == n_shut - 1);
  endtask

  // wait until every queued word is in and every result is out
  task automatic drain();
    do @(negedge clk);
    while (src_bytes.size() != 0 || in_if.valid || span_results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OW-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_OPEN_KIND) cfg_kind = val[1:0];
    else cfg_base = val;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [1:0]    ph_kinds [8];
    logic [OW-1:0] base;
    int            mark;
    int            roll;
    ph_kinds = '{KIND_PAREN, KIND_BRACKET, KIND_BRACE, KIND_LITERAL,
                 KIND_PAREN, KIND_BRACKET, KIND_BRACE, KIND_LITERAL};
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.first_byte = 1'b0;
    in_if.last_byte  = 1'b0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset config: paren opener, offset 0
    put("a", 1'b0, 1'b0);                 // no scan yet: ignored
    put("x", 1'b1, 1'b0);                 // plain match
    put(CHAR_RPAREN, 1'b0, 1'b0);
    put(CHAR_RPAREN, 1'b0, 1'b0);         // after match: ignored
    put(CHAR_QUOTE, 1'b1, 1'b0);          // quote hides the closer
    put(CHAR_RPAREN, 1'b0, 1'b0);
    put(CHAR_QUOTE, 1'b0, 1'b0);
    put(CHAR_RPAREN, 1'b0, 1'b0);
    put(CHAR_BSLASH, 1'b1, 1'b0);         // escaped closer
    put(CHAR_RPAREN, 1'b0, 1'b0);
    put(CHAR_RPAREN, 1'b0, 1'b0);
    put(CHAR_LBRACE, 1'b1, 1'b0);         // brace literal inside a paren
    put(CHAR_RPAREN, 1'b0, 1'b0);
    put(CHAR_RBRACE, 1'b0, 1'b0);
    put(CHAR_RPAREN, 1'b0, 1'b0);
    put(CHAR_NEWLINE, 1'b1, 1'b0);        // source ends inside a quote
    put(CHAR_LPAREN, 1'b0, 1'b0);
    put(CHAR_NEWLINE, 1'b0, 1'b0);
    put(CHAR_QUOTE, 1'b0, 1'b0);
    put("a", 1'b0, 1'b1);
    put(CHAR_BSLASH, 1'b1, 1'b1);         // backslash as final byte
    put(8'hFF, 1'b1, 1'b1);               // one-byte source
    put(8'h00, 1'b1, 1'b0);               // bracket frame, match on last byte
    put(CHAR_LBRACK, 1'b0, 1'b0);
    put(CHAR_RBRACK, 1'b0, 1'b0);
    put(CHAR_RPAREN, 1'b0, 1'b1);
    drain();

    // random phases, each with its own opener kind and start offset
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0, 6:    base = '0;
        1:       base = '1;
        3:       base = OW'(24'hFFFFF0);   // end offset saturates mid-scan
        default: base = OW'($urandom);
      endcase
      write_reg(CFG_OPEN_KIND, OW'(ph_kinds[ph]));
      write_reg(CFG_START_OFFSET, base);
      full_speed = (ph == 4);
      if (ph == 2) queue_flood(256);
      if (ph == 3) queue_flood($urandom_range(253, 256));
      mark = n_words;
      while (n_words - mark < 50) begin
        roll = $urandom_range(99);
        if (roll < 65) queue_scan(1'b1);
        else if (roll < 82) queue_scan(1'b0);
        else if (roll < 94 && cfg_kind != KIND_LITERAL) queue_deep($urandom_range(30, 35));
        else put(8'($urandom), 1'b0, 1'($urandom_range(1)));
      end
      // sender holds off here until every result is back
      drain();
    end
    full_speed = 1'b0;

    repeat (8) @(posedge clk);
    if (n_fail == 0 && span_results_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
design/nds_pkg.sv
design/nds_intf.sv
design/nds_ram.sv
design/nds_front.sv
design/nds_fifo.sv
design/nds_back.sv
design/nested_delimiter_span_scanner_core.sv
tb/tb.sv
